// File: src/bspd_pkg.sv
// Shared types and constants for the bike speed page decoder.
package bspd_pkg;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_SPEED = 2'd1;
  localparam logic [1:0] EV_STOP  = 2'd2;

  localparam logic [1:0] REG_WHEEL = 2'd0;
  localparam logic [1:0] REG_STOP  = 2'd1;
  localparam logic [1:0] REG_MAX   = 2'd2;

  localparam int MULT_W = 18;
  localparam int WHEEL_FACTOR = 36;
  localparam int TICKS_PER_S = 1024;

  localparam logic [11:0] WHEEL_RESET = 12'd2096;
  localparam logic [7:0]  STOP_RESET  = 8'd12;
  localparam logic [23:0] MAX_RESET   = 24'd100000;
  localparam logic [23:0] SPEED_SAT   = 24'hFFFFFF;

  typedef struct packed {
    logic [1:0]  evt;
    logic [23:0] speed;
    logic [31:0] revs;
    logic [24:0] optime;
    logic [7:0]  maker;
    logic [15:0] serial;
    logic [7:0]  hw;
    logic [7:0]  sw;
    logic [7:0]  model;
  } result_t;

  typedef struct packed {
    logic        compute;
    logic [15:0] drev;
    logic [15:0] dt;
    result_t     info;
  } qentry_t;

endpackage

// File: src/bike_speed_page_decoder.sv
// Top level of the bike speed page decoder: configuration registers and channel wiring.
// A request with a speed to compute passes the one-bit-per-cycle divide and multiply
// and a four-step reciprocal scaling. Other requests go to the result register at one per
// cycle while the speed unit is idle and the output is free; a two-entry queue lets the
// front keep accepting until it is full. The speed unit takes no new request while busy.
// Reset (rst, synchronous) restores register defaults and clears all page and motion state.
module bike_speed_page_decoder #(
  parameter int FRAC_SCALE = 1000,
  parameter int ACCUM_REV_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  page_byte,
  input  logic [7:0]  data_byte_1,
  input  logic [7:0]  data_byte_2,
  input  logic [7:0]  data_byte_3,
  input  logic [7:0]  event_time_low,
  input  logic [7:0]  event_time_high,
  input  logic [7:0]  rev_count_low,
  input  logic [7:0]  rev_count_high,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  speed_event,
  output logic [23:0] speed_milli_kmh,
  output logic [31:0] accumulated_revs,
  output logic [24:0] operating_time_s,
  output logic [7:0]  manufacturer_id,
  output logic [15:0] serial_upper,
  output logic [7:0]  hardware_version,
  output logic [7:0]  software_version,
  output logic [7:0]  model_number,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  logic [11:0] wheel;
  logic [7:0] stop_limit;
  logic [23:0] speed_limit;
  logic accept, q_full, q_valid, q_pop;
  bspd_pkg::qentry_t f_entry, q_entry;
  bspd_pkg::result_t res;

  assign cfg_ready = 1'b1;
  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel <= bspd_pkg::WHEEL_RESET;
      stop_limit <= bspd_pkg::STOP_RESET;
      speed_limit <= bspd_pkg::MAX_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        bspd_pkg::REG_WHEEL: wheel <= cfg_data[11:0];
        bspd_pkg::REG_STOP:  stop_limit <= cfg_data[7:0];
        bspd_pkg::REG_MAX:   speed_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  bspd_front #(.ACCUM_REV_BITS(ACCUM_REV_BITS)) u_front (
    .clk(clk), .rst(rst), .accept(accept),
    .page_byte(page_byte), .data_byte_1(data_byte_1), .data_byte_2(data_byte_2),
    .data_byte_3(data_byte_3), .event_time_low(event_time_low),
    .event_time_high(event_time_high), .rev_count_low(rev_count_low),
    .rev_count_high(rev_count_high), .stop_limit(stop_limit), .entry(f_entry)
  );

  bspd_queue u_queue (
    .clk(clk), .rst(rst), .push(accept), .push_data(f_entry), .full(q_full),
    .pop(q_pop), .valid(q_valid), .pop_data(q_entry)
  );

  bspd_back #(.FRAC_SCALE(FRAC_SCALE)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_data(q_entry), .q_pop(q_pop),
    .wheel(wheel), .speed_limit(speed_limit), .out_valid(out_valid),
    .out_ready(out_ready), .res(res)
  );

  assign speed_event = res.evt;
  assign speed_milli_kmh = res.speed;
  assign accumulated_revs = res.revs;
  assign operating_time_s = res.optime;
  assign manufacturer_id = res.maker;
  assign serial_upper = res.serial;
  assign hardware_version = res.hw;
  assign software_version = res.sw;
  assign model_number = res.model;

endmodule

// File: src/bspd_front.sv
// Front end: page mode machine, page decoding, motion tracking and request classification.
module bspd_front #(
  parameter int ACCUM_REV_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       page_byte,
  input  logic [7:0]       data_byte_1,
  input  logic [7:0]       data_byte_2,
  input  logic [7:0]       data_byte_3,
  input  logic [7:0]       event_time_low,
  input  logic [7:0]       event_time_high,
  input  logic [7:0]       rev_count_low,
  input  logic [7:0]       rev_count_high,
  input  logic [7:0]       stop_limit,
  output bspd_pkg::qentry_t entry
);

  typedef enum logic [1:0] {M_INIT = 2'd0, M_STD = 2'd1, M_EXT = 2'd2} mode_t;

  mode_t mode, mode_next;
  logic [7:0] prev_page;
  logic [15:0] prev_time, prev_revs;
  logic [8:0] unch, unch_next, unch_inc;
  logic first_pend, first_pend_next;
  logic [ACCUM_REV_BITS-1:0] rev_total, rev_total_next;
  logic [24:0] optime, optime_next;
  logic [7:0] maker, maker_next, hw, hw_next, sw, sw_next, model, model_next;
  logic [15:0] serial, serial_next;
  logic [15:0] now_time, now_revs, drev, dt;
  logic decode_en, same;
  logic [1:0] evt;
  logic compute;

  always_comb begin
    now_time = {event_time_high, event_time_low};
    now_revs = {rev_count_high, rev_count_low};
    drev = now_revs - prev_revs;
    dt = now_time - prev_time;
    mode_next = mode;
    decode_en = 1'b0;
    case (mode)
      M_INIT: mode_next = M_STD;
      M_STD: begin
        if (prev_page != page_byte) begin
          mode_next = M_EXT;
          decode_en = 1'b1;
        end
      end
      default: decode_en = 1'b1;
    endcase
    optime_next = optime;
    maker_next = maker;
    serial_next = serial;
    hw_next = hw;
    sw_next = sw;
    model_next = model;
    if (decode_en) begin
      case (page_byte[6:0])
        7'd1: optime_next = {data_byte_3, data_byte_2, data_byte_1, 1'b0};
        7'd2: begin
          maker_next = data_byte_1;
          serial_next = {data_byte_3, data_byte_2};
        end
        7'd3: begin
          hw_next = data_byte_1;
          sw_next = data_byte_2;
          model_next = data_byte_3;
        end
        default: ;
      endcase
    end
    same = (now_time == prev_time) && (now_revs == prev_revs);
    unch_inc = (unch == 9'd511) ? unch : unch + 9'd1;
    unch_next = 9'd0;
    first_pend_next = first_pend;
    evt = bspd_pkg::EV_NONE;
    compute = 1'b0;
    if (same) begin
      unch_next = unch_inc;
      if (unch_inc > {1'b0, stop_limit}) begin
        evt = bspd_pkg::EV_STOP;
      end
    end else if (dt != 16'd0) begin
      compute = !first_pend;
      first_pend_next = 1'b0;
    end
    rev_total_next = rev_total + ACCUM_REV_BITS'(drev);
    entry.compute = compute;
    entry.drev = drev;
    entry.dt = dt;
    entry.info.evt = evt;
    entry.info.speed = 24'd0;
    entry.info.revs = 32'(rev_total_next);
    entry.info.optime = optime_next;
    entry.info.maker = maker_next;
    entry.info.serial = serial_next;
    entry.info.hw = hw_next;
    entry.info.sw = sw_next;
    entry.info.model = model_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_INIT;
      prev_page <= 8'd0;
      prev_time <= 16'd0;
      prev_revs <= 16'd0;
      unch <= 9'd0;
      first_pend <= 1'b1;
      rev_total <= '0;
      optime <= 25'd0;
      maker <= 8'd0;
      serial <= 16'd0;
      hw <= 8'd0;
      sw <= 8'd0;
      model <= 8'd0;
    end else if (accept) begin
      mode <= mode_next;
      prev_page <= page_byte;
      prev_time <= now_time;
      prev_revs <= now_revs;
      unch <= unch_next;
      first_pend <= first_pend_next;
      rev_total <= rev_total_next;
      optime <= optime_next;
      maker <= maker_next;
      serial <= serial_next;
      hw <= hw_next;
      sw <= sw_next;
      model <= model_next;
    end
  end

endmodule

// File: src/bspd_queue.sv
// Two-entry queue between the front end and the speed unit.
module bspd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bspd_pkg::qentry_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output bspd_pkg::qentry_t pop_data
);

  bspd_pkg::qentry_t mem [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push || pop) else $error("Request pushed into a full queue.");
`endif

endmodule

// File: src/bspd_back.sv
// Speed unit: serial divide, serial wheel multiply, reciprocal scaling, plus the result register.
module bspd_back #(
  parameter int FRAC_SCALE = 1000
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  bspd_pkg::qentry_t  q_data,
  output logic               q_pop,
  input  logic [11:0]        wheel,
  input  logic [23:0]        speed_limit,
  output logic               out_valid,
  input  logic               out_ready,
  output bspd_pkg::result_t  res
);

  localparam int SW = $clog2(FRAC_SCALE + 1);
  localparam int NUMW = 26 + SW;
  localparam int MW = bspd_pkg::MULT_W;
  localparam int PW = NUMW + MW;
  localparam int DIVC = 10 * FRAC_SCALE;
  localparam int RW = 17;
  localparam int CW = $clog2(PW);
  localparam int RL = $clog2(DIVC);
  localparam int RS = PW + RL;
  localparam int PRW = 2 * PW + 1;
  localparam int QW = PRW - RS;
  localparam int H = (PW + 1) / 2;
  localparam int OPW = H + 1;
  localparam logic [PRW-1:0] RECIP_FULL =
    ((PRW'(1) << RS) + PRW'(DIVC - 1)) / PRW'(DIVC);
  localparam logic [PW:0] RECIP = RECIP_FULL[PW:0];

  typedef enum logic [2:0] {S_IDLE, S_DIV1, S_MUL, S_RCP, S_FIN} state_t;

  state_t state;
  logic [CW-1:0] cnt;
  logic [PW-1:0] dvd, dvd_shift, mcand, acc, acc_sum;
  logic [RW-2:0] rem;
  logic [RW-1:0] dvs, trial, trial_sub;
  logic [MW-1:0] mplier;
  logic ge;
  logic [OPW-1:0] op_a, op_b;
  logic [2*OPW-1:0] pp;
  logic [PRW-1:0] prod, prod_sum, pp_sh;
  logic [QW-1:0] quot;
  logic done;
  bspd_pkg::result_t cur, fin_res;

  assign q_pop = (state == S_IDLE) && q_valid && (!out_valid || out_ready);

  // The final scaling multiplies by a fixed-point reciprocal in four partial products.
  always_comb begin
    trial = {rem, dvd[PW-1]};
    ge = (trial >= dvs);
    trial_sub = trial - dvs;
    dvd_shift = {dvd[PW-2:0], ge};
    acc_sum = acc + (mplier[0] ? mcand : '0);
    case (cnt[1:0])
      2'd3: begin
        op_a = OPW'(dvd[H-1:0]);
        op_b = OPW'(RECIP[H-1:0]);
      end
      2'd2: begin
        op_a = OPW'(dvd[H-1:0]);
        op_b = OPW'(RECIP[PW:H]);
      end
      2'd1: begin
        op_a = OPW'(dvd[PW-1:H]);
        op_b = OPW'(RECIP[H-1:0]);
      end
      default: begin
        op_a = OPW'(dvd[PW-1:H]);
        op_b = OPW'(RECIP[PW:H]);
      end
    endcase
    pp = op_a * op_b;
    case (cnt[1:0])
      2'd3: pp_sh = PRW'(pp);
      2'd2, 2'd1: pp_sh = PRW'(pp) << H;
      default: pp_sh = PRW'(pp) << (2 * H);
    endcase
    prod_sum = prod + pp_sh;
    quot = prod[PRW-1:RS];
    fin_res = cur;
    if (quot < QW'(speed_limit)) begin
      fin_res.evt = bspd_pkg::EV_SPEED;
      fin_res.speed = (quot > QW'(bspd_pkg::SPEED_SAT)) ? bspd_pkg::SPEED_SAT : quot[23:0];
    end else begin
      fin_res.evt = bspd_pkg::EV_NONE;
      fin_res.speed = 24'd0;
    end
    done = (q_pop && !q_data.compute) || (state == S_FIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (done) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            if (q_data.compute) begin
              cur <= q_data.info;
              dvd <= PW'(q_data.drev) * PW'(bspd_pkg::TICKS_PER_S * FRAC_SCALE);
              dvs <= RW'(q_data.dt);
              rem <= '0;
              cnt <= CW'(PW - 1);
              state <= S_DIV1;
            end else begin
              res <= q_data.info;
            end
          end
        end
        S_DIV1: begin
          dvd <= dvd_shift;
          rem <= ge ? trial_sub[RW-2:0] : trial[RW-2:0];
          if (cnt == '0) begin
            mcand <= dvd_shift;
            mplier <= MW'({6'd0, wheel} * 18'(bspd_pkg::WHEEL_FACTOR));
            acc <= '0;
            cnt <= CW'(MW - 1);
            state <= S_MUL;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_MUL: begin
          acc <= acc_sum;
          mcand <= {mcand[PW-2:0], 1'b0};
          mplier <= {1'b0, mplier[MW-1:1]};
          if (cnt == '0) begin
            dvd <= acc_sum;
            prod <= '0;
            cnt <= CW'(3);
            state <= S_RCP;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_RCP: begin
          prod <= prod_sum;
          if (cnt == '0) begin
            state <= S_FIN;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_FIN: begin
          res <= fin_res;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_no_output: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !out_valid) else $error("Result shown while the unit is busy.");
  a_speed_only_on_event: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.evt != bspd_pkg::EV_SPEED) |-> (res.speed == 24'd0))
    else $error("Nonzero speed without a speed event.");
`endif

endmodule

// File: sim/bike_speed_page_decoder_tb.sv
// Testbench for the bike speed page decoder: page requests, speed prediction and result checks.
`timescale 1ns / 1ps

module bike_speed_page_decoder_tb;

  localparam int FRAC = 1000;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [7:0] page;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [15:0] etime;
    logic [15:0] revs;
  } page_req_t;

  typedef enum logic [1:0] {MODE_INIT, MODE_STD, MODE_EXT} page_mode_t;

  class speed_scoreboard;
    logic [11:0] wheel_mm;
    logic [7:0] stop_limit;
    logic [23:0] speed_limit;
    page_mode_t mode;
    logic [7:0] last_page;
    logic [15:0] last_time;
    logic [15:0] last_revs;
    logic [8:0] same_count;
    bit first_pending;
    logic [31:0] rev_total;
    logic [24:0] optime;
    logic [7:0] maker;
    logic [15:0] serial;
    logic [7:0] hw;
    logic [7:0] sw;
    logic [7:0] model;
    bspd_pkg::result_t pending_results[$];
    int errors;

    function void clear();
      wheel_mm = bspd_pkg::WHEEL_RESET;
      stop_limit = bspd_pkg::STOP_RESET;
      speed_limit = bspd_pkg::MAX_RESET;
      mode = MODE_INIT;
      last_page = 0;
      last_time = 0;
      last_revs = 0;
      same_count = 0;
      first_pending = 1;
      rev_total = 0;
      optime = 0;
      maker = 0;
      serial = 0;
      hw = 0;
      sw = 0;
      model = 0;
      pending_results.delete();
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [23:0] value);
      case (idx)
        bspd_pkg::REG_WHEEL: wheel_mm = value[11:0];
        bspd_pkg::REG_STOP: stop_limit = value[7:0];
        bspd_pkg::REG_MAX: speed_limit = value;
        default: ;
      endcase
    endfunction

    function void decode(page_req_t r);
      case (r.page[6:0])
        7'd1: optime = {r.b3, r.b2, r.b1, 1'b0};
        7'd2: begin
          maker = r.b1;
          serial = {r.b3, r.b2};
        end
        7'd3: begin
          hw = r.b1;
          sw = r.b2;
          model = r.b3;
        end
        default: ;
      endcase
    endfunction

    function void note_request(page_req_t r);
      bspd_pkg::result_t res;
      logic [15:0] drev;
      logic [15:0] dt;
      longint unsigned num;
      longint unsigned q;
      longint unsigned f;
      longint unsigned v;
      drev = r.revs - last_revs;
      res = '0;
      res.evt = bspd_pkg::EV_NONE;
      if (mode == MODE_INIT) begin
        mode = MODE_STD;
      end else if (mode == MODE_STD) begin
        if (last_page != r.page) begin
          mode = MODE_EXT;
          decode(r);
        end
      end else begin
        decode(r);
      end
      last_page = r.page;
      if (r.etime == last_time && r.revs == last_revs) begin
        if (same_count < 511) same_count++;
        if (same_count > stop_limit) res.evt = bspd_pkg::EV_STOP;
      end else begin
        dt = r.etime - last_time;
        same_count = 0;
        if (dt != 0) begin
          num = longint'(drev) * 1024;
          q = num / dt;
          f = ((num % dt) * FRAC) / dt;
          v = ((q * FRAC + f) * wheel_mm * 36) / (10 * FRAC);
          if (!first_pending && v < speed_limit) begin
            res.evt = bspd_pkg::EV_SPEED;
            res.speed = (v > 24'hFFFFFF) ? bspd_pkg::SPEED_SAT : v[23:0];
          end
          first_pending = 0;
        end
      end
      rev_total = rev_total + drev;
      last_time = r.etime;
      last_revs = r.revs;
      res.revs = rev_total;
      res.optime = optime;
      res.maker = maker;
      res.serial = serial;
      res.hw = hw;
      res.sw = sw;
      res.model = model;
      pending_results.push_back(res);
    endfunction

    function void check_result(bspd_pkg::result_t got);
      bspd_pkg::result_t exp;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %p", got);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      if (got.evt !== exp.evt) begin
        $error("speed_event expected %0d actual %0d", exp.evt, got.evt);
        errors++;
      end
      if (got.speed !== exp.speed) begin
        $error("speed_milli_kmh expected %0d actual %0d", exp.speed, got.speed);
        errors++;
      end
      if (got.revs !== exp.revs) begin
        $error("accumulated_revs expected %0d actual %0d", exp.revs, got.revs);
        errors++;
      end
      if (got.optime !== exp.optime) begin
        $error("operating_time_s expected %0d actual %0d", exp.optime, got.optime);
        errors++;
      end
      if (got.maker !== exp.maker) begin
        $error("manufacturer_id expected %0d actual %0d", exp.maker, got.maker);
        errors++;
      end
      if (got.serial !== exp.serial) begin
        $error("serial_upper expected %0d actual %0d", exp.serial, got.serial);
        errors++;
      end
      if (got.hw !== exp.hw) begin
        $error("hardware_version expected %0d actual %0d", exp.hw, got.hw);
        errors++;
      end
      if (got.sw !== exp.sw) begin
        $error("software_version expected %0d actual %0d", exp.sw, got.sw);
        errors++;
      end
      if (got.model !== exp.model) begin
        $error("model_number expected %0d actual %0d", exp.model, got.model);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  page_req_t req = '0;
  logic out_valid;
  logic out_ready = 0;
  bspd_pkg::result_t res_out;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;
  bit long_hold = 0;
  int idle_cycles = 0;

  speed_scoreboard sb = new();

  always #5 clk = ~clk;

  bike_speed_page_decoder dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .page_byte(req.page), .data_byte_1(req.b1), .data_byte_2(req.b2),
    .data_byte_3(req.b3),
    .event_time_low(req.etime[7:0]), .event_time_high(req.etime[15:8]),
    .rev_count_low(req.revs[7:0]), .rev_count_high(req.revs[15:8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .speed_event(res_out.evt), .speed_milli_kmh(res_out.speed),
    .accumulated_revs(res_out.revs), .operating_time_s(res_out.optime),
    .manufacturer_id(res_out.maker), .serial_upper(res_out.serial),
    .hardware_version(res_out.hw), .software_version(res_out.sw),
    .model_number(res_out.model),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(res_out);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > STALL_LIMIT) begin
      $display("[bike_speed_page_decoder] ERROR");
      $finish;
    end
  end

  initial begin
    int phase;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 0;
      end else begin
        phase = (phase + 1) % 64;
        out_ready <= (phase < 32) ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic send_page(page_req_t r);
    @(negedge clk);
    in_valid <= 1;
    req <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(r);
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] value);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, value);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic drain();
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Builds a page that moves on from the last one by a plausible wheel step (random if wild).
  function automatic page_req_t next_page(bit wild);
    page_req_t r;
    r.page = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) != 0) r.page = {r.page[7], 4'd0, 3'($urandom_range(0, 4))};
    r.b1 = 8'($urandom);
    r.b2 = 8'($urandom);
    r.b3 = 8'($urandom);
    if (wild) begin
      r.etime = 16'($urandom);
      r.revs = 16'($urandom);
    end else begin
      r.etime = sb.last_time + 16'($urandom_range(200, 3000));
      r.revs = sb.last_revs + 16'($urandom_range(0, 6));
    end
    return r;
  endfunction

  task automatic send_random(int count);
    int burst;
    page_req_t r;
    while (count > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && count > 0) begin
        case ($urandom_range(0, 9))
          0: r = next_page(1);
          1, 2: begin
            r = next_page(0);
            r.etime = sb.last_time;
            r.revs = sb.last_revs;
          end
          default: r = next_page(0);
        endcase
        send_page(r);
        burst--;
        count--;
      end
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 30)) @(negedge clk);
    end
  endtask

  initial begin
    page_req_t r;
    sb.clear();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: first speed suppressed, page mode walk, all pages, extremes.
    send_page('{8'h01, 8'h11, 8'h22, 8'h33, 16'd0, 16'd0});
    send_page('{8'h01, 8'hFF, 8'hFF, 8'hFF, 16'd1024, 16'd2});
    send_page('{8'h81, 8'hFF, 8'hFF, 8'hFF, 16'd2048, 16'd4});
    send_page('{8'h02, 8'hAB, 8'hCD, 8'hEF, 16'd3072, 16'd6});
    send_page('{8'h03, 8'h01, 8'h02, 8'h03, 16'd3072, 16'd6});
    send_page('{8'h00, 8'h55, 8'h55, 8'h55, 16'd4096, 16'd6});
    send_page('{8'h7F, 8'h00, 8'h00, 8'h00, 16'd4096, 16'd9});
    send_page('{8'hFF, 8'hFF, 8'h00, 8'hFF, 16'd4097, 16'd65535});
    send_page('{8'h01, 8'h00, 8'h00, 8'h00, 16'd0, 16'd3});
    send_page('{8'h82, 8'h00, 8'hFF, 8'h00, 16'd65535, 16'd4});
    for (int i = 0; i < 14; i++) send_page('{8'h82, 8'h00, 8'hFF, 8'h00, 16'd65535, 16'd4});
    drain();

    write_reg(bspd_pkg::REG_WHEEL, 24'd4095);
    write_reg(bspd_pkg::REG_STOP, 24'd0);
    write_reg(bspd_pkg::REG_MAX, 24'hFFFFFF);
    send_random(100);
    drain();

    write_reg(bspd_pkg::REG_WHEEL, 24'd0);
    write_reg(bspd_pkg::REG_STOP, 24'd255);
    write_reg(bspd_pkg::REG_MAX, 24'd0);
    send_random(40);
    drain();

    write_reg(bspd_pkg::REG_WHEEL, 24'd700);
    write_reg(bspd_pkg::REG_STOP, 24'd3);
    write_reg(bspd_pkg::REG_MAX, 24'd60000);
    fork
      begin
        long_hold = 1;
        repeat (600) @(posedge clk);
        long_hold = 0;
      end
      send_random(20);
    join
    send_random(120);
    drain();

    write_reg(bspd_pkg::REG_WHEEL, 24'(bspd_pkg::WHEEL_RESET));
    write_reg(bspd_pkg::REG_STOP, 24'(bspd_pkg::STOP_RESET));
    write_reg(bspd_pkg::REG_MAX, bspd_pkg::MAX_RESET);
    send_random(120);
    drain();

    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("[bike_speed_page_decoder] OK");
    end else begin
      $display("[bike_speed_page_decoder] ERROR");
    end
    $finish;
  end
endmodule
